@@ rtl/core/hsb_pkg.sv @@
package hsb_pkg;

   localparam logic [2:0] MODE_OFF    = 3'd0;
   localparam logic [2:0] MODE_STEADY = 3'd1;
   localparam logic [2:0] MODE_BLINK  = 3'd2;
   localparam logic [2:0] MODE_FADE   = 3'd3;
   localparam logic [2:0] MODE_STROBE = 3'd4;

   localparam logic [2:0] REG_MODE          = 3'd0;
   localparam logic [2:0] REG_SATURATION    = 3'd1;
   localparam logic [2:0] REG_START_HUE     = 3'd2;
   localparam logic [2:0] REG_START_BRIGHT  = 3'd3;
   localparam logic [2:0] REG_FADE_PERIOD   = 3'd4;
   localparam logic [2:0] REG_BLINK_PERIOD  = 3'd5;
   localparam logic [2:0] REG_STROBE_PERIOD = 3'd6;

   localparam logic [9:0]  HUE_MAX     = 10'd764;
   localparam logic [5:0]  BRIGHT_MAX  = 6'd63;
   localparam logic [7:0]  SAT_MAX     = 8'd128;
   localparam logic [9:0]  BLINK_STEP  = 10'd50;
   localparam logic [9:0]  FADE_STEP   = 10'd1;
   localparam logic [9:0]  SEG_ONE     = 10'd255;
   localparam logic [9:0]  SEG_TWO     = 10'd510;
   localparam logic [7:0]  DUTY_MAX    = 8'd255;
   localparam logic signed [19:0] HUE_BASE = 20'sd10880;

   localparam logic signed [10:0] OFS_170 = 11'sd170;
   localparam logic signed [10:0] OFS_85  = 11'sd85;
   localparam logic signed [10:0] OFS_425 = 11'sd425;
   localparam logic signed [10:0] OFS_340 = 11'sd340;
   localparam logic signed [10:0] OFS_680 = 11'sd680;
   localparam logic signed [10:0] OFS_595 = 11'sd595;

   localparam logic [9:0]  FADE_RESET    = 10'd150;
   localparam logic [9:0]  FADE_LO       = 10'd200;
   localparam logic [9:0]  FADE_HI       = 10'd1000;
   localparam logic [11:0] BLINK_RESET   = 12'd1274;
   localparam logic [11:0] BLINK_LO      = 12'd700;
   localparam logic [11:0] BLINK_HI      = 12'd2400;
   localparam logic [8:0]  STROBE_RESET  = 9'd40;
   localparam logic [8:0]  STROBE_LO     = 9'd40;
   localparam logic [8:0]  STROBE_HI     = 9'd400;

   localparam logic [0:63][7:0] GAMMA_LUT = {
      8'd0,   8'd0,   8'd1,   8'd1,   8'd1,   8'd2,   8'd2,   8'd2,
      8'd2,   8'd2,   8'd2,   8'd3,   8'd3,   8'd3,   8'd3,   8'd4,
      8'd4,   8'd4,   8'd5,   8'd5,   8'd6,   8'd6,   8'd7,   8'd8,
      8'd8,   8'd9,   8'd10,  8'd11,  8'd12,  8'd13,  8'd14,  8'd15,
      8'd17,  8'd18,  8'd20,  8'd22,  8'd24,  8'd26,  8'd28,  8'd31,
      8'd34,  8'd37,  8'd40,  8'd44,  8'd48,  8'd52,  8'd57,  8'd62,
      8'd68,  8'd74,  8'd81,  8'd89,  8'd97,  8'd106, 8'd116, 8'd126,
      8'd138, 8'd150, 8'd164, 8'd179, 8'd196, 8'd214, 8'd234, 8'd255};

   typedef struct packed {
      logic [2:0]  mode;
      logic [7:0]  saturation;
      logic [9:0]  start_hue;
      logic [5:0]  start_bright;
      logic [9:0]  fade_period;
      logic [11:0] blink_period;
      logic [8:0]  strobe_period;
   } cfg_type;

   typedef struct packed {
      logic       hue_load;
      logic [9:0] hue_val;
      logic       bright_load;
      logic [5:0] bright_val;
   } load_type;

   typedef struct packed {
      logic start;
      logic ack;
   } mix_ctl_type;

   function automatic logic [7:0] gamma_lookup(input logic [5:0] idx);
      return GAMMA_LUT[idx];
   endfunction

endpackage

@@ rtl/core/hsb_regs.sv @@
module hsb_regs
   import hsb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   input  logic [2:0]  csr_index,
   input  logic [11:0] csr_data,
   output cfg_type     cfg,
   output load_type    load
);

   cfg_type cfg_ff, cfg_in;

   logic [2:0]  mode_raw;
   logic [7:0]  sat_raw;
   logic [9:0]  hue_raw;
   logic [9:0]  hue_clip;
   logic [9:0]  fade_raw;
   logic [8:0]  strobe_raw;
   logic [9:0]  fade_clip;
   logic [11:0] blink_clip;
   logic [8:0]  strobe_clip;

   always_comb begin
      mode_raw   = csr_data[2:0];
      sat_raw    = csr_data[7:0];
      hue_raw    = csr_data[9:0];
      fade_raw   = csr_data[9:0];
      strobe_raw = csr_data[8:0];
      hue_clip   = (hue_raw > HUE_MAX) ? '0 : hue_raw;
      fade_clip  = (fade_raw < FADE_LO) ? FADE_LO :
                   ((fade_raw > FADE_HI) ? FADE_HI : fade_raw);
      blink_clip = (csr_data < BLINK_LO) ? BLINK_LO :
                   ((csr_data > BLINK_HI) ? BLINK_HI : csr_data);
      strobe_clip = (strobe_raw < STROBE_LO) ? STROBE_LO :
                    ((strobe_raw > STROBE_HI) ? STROBE_HI : strobe_raw);
   end

   always_comb begin
      cfg_in           = cfg_ff;
      load.hue_load    = 1'b0;
      load.hue_val     = hue_clip;
      load.bright_load = 1'b0;
      load.bright_val  = csr_data[5:0];
      if (csr_valid) begin
         case (csr_index)
            REG_MODE: begin
               cfg_in.mode = (mode_raw > MODE_STROBE) ? MODE_OFF : mode_raw;
            end
            REG_SATURATION: begin
               cfg_in.saturation = (sat_raw > SAT_MAX) ? SAT_MAX : sat_raw;
            end
            REG_START_HUE: begin
               cfg_in.start_hue = hue_clip;
               load.hue_load    = 1'b1;
            end
            REG_START_BRIGHT: begin
               cfg_in.start_bright = csr_data[5:0];
               load.bright_load    = 1'b1;
            end
            REG_FADE_PERIOD: begin
               cfg_in.fade_period = fade_clip;
            end
            REG_BLINK_PERIOD: begin
               cfg_in.blink_period = blink_clip;
            end
            REG_STROBE_PERIOD: begin
               cfg_in.strobe_period = strobe_clip;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode          <= MODE_OFF;
         cfg_ff.saturation    <= SAT_MAX;
         cfg_ff.start_hue     <= '0;
         cfg_ff.start_bright  <= BRIGHT_MAX;
         cfg_ff.fade_period   <= FADE_RESET;
         cfg_ff.blink_period  <= BLINK_RESET;
         cfg_ff.strobe_period <= STROBE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ rtl/core/hsb_fx.sv @@
module hsb_fx
   import hsb_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  logic       advance,
   input  cfg_type    cfg,
   input  load_type   load,
   output logic [9:0] hue,
   output logic [5:0] bright
);

   logic [9:0]  hue_ff, hue_in;
   logic [5:0]  bright_ff, bright_in;
   logic [9:0]  fade_cnt_ff, fade_cnt_in;
   logic [11:0] blink_cnt_ff, blink_cnt_in;
   logic [8:0]  strobe_cnt_ff, strobe_cnt_in;
   logic        dark_ff, dark_in;

   logic [10:0] hue_sum;
   logic [9:0]  hue_next;
   logic [9:0]  fade_nxt;
   logic [11:0] blink_nxt;
   logic [8:0]  strobe_nxt;
   logic        tick;

   always_comb begin
      tick       = step & advance;
      hue_sum    = {1'b0, hue_ff} +
                   {1'b0, ((cfg.mode == MODE_BLINK) ? BLINK_STEP : FADE_STEP)};
      hue_next   = (hue_sum > {1'b0, HUE_MAX}) ? '0 : hue_sum[9:0];
      fade_nxt   = fade_cnt_ff + 10'd1;
      blink_nxt  = blink_cnt_ff + 12'd1;
      strobe_nxt = strobe_cnt_ff + 9'd1;

      hue_in        = hue_ff;
      bright_in     = bright_ff;
      fade_cnt_in   = fade_cnt_ff;
      blink_cnt_in  = blink_cnt_ff;
      strobe_cnt_in = strobe_cnt_ff;
      dark_in       = dark_ff;

      if (tick) begin
         case (cfg.mode)
            MODE_FADE: begin
               if (fade_nxt >= cfg.fade_period) begin
                  fade_cnt_in = '0;
                  hue_in      = hue_next;
               end else begin
                  fade_cnt_in = fade_nxt;
               end
            end
            MODE_BLINK: begin
               if (blink_nxt >= cfg.blink_period) begin
                  blink_cnt_in = '0;
                  hue_in       = hue_next;
               end else begin
                  blink_cnt_in = blink_nxt;
               end
            end
            MODE_STROBE: begin
               if (strobe_nxt >= cfg.strobe_period) begin
                  strobe_cnt_in = '0;
                  dark_in       = ~dark_ff;
                  bright_in     = dark_ff ? BRIGHT_MAX : '0;
               end else begin
                  strobe_cnt_in = strobe_nxt;
               end
            end
            default: begin
            end
         endcase
      end

      if (load.hue_load) begin
         hue_in = load.hue_val;
      end
      if (load.bright_load) begin
         bright_in = load.bright_val;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hue_ff        <= '0;
         bright_ff     <= BRIGHT_MAX;
         fade_cnt_ff   <= '0;
         blink_cnt_ff  <= '0;
         strobe_cnt_ff <= '0;
         dark_ff       <= 1'b0;
      end else begin
         hue_ff        <= hue_in;
         bright_ff     <= bright_in;
         fade_cnt_ff   <= fade_cnt_in;
         blink_cnt_ff  <= blink_cnt_in;
         strobe_cnt_ff <= strobe_cnt_in;
         dark_ff       <= dark_in;
      end
   end

   assign hue    = hue_ff;
   assign bright = bright_ff;

endmodule

@@ rtl/core/hsb_mix.sv @@
module hsb_mix
   import hsb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  mix_ctl_type ctl,
   input  logic [9:0]  hue,
   input  logic [5:0]  bright,
   input  logic [7:0]  saturation,
   output logic [7:0]  red,
   output logic [7:0]  green,
   output logic [7:0]  blue,
   output logic        done
);

   localparam logic [2:0] STEP_LAST = 3'd6;

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [2:0]        step_ff, step_in;
   logic signed [19:0] prod_ff, prod_in;
   logic [7:0]        chan0_ff, chan1_ff, chan2_ff;
   logic [7:0]        chan0_in, chan1_in, chan2_in;
   logic [7:0]        red_ff, green_ff, blue_ff;
   logic [7:0]        red_in, green_in, blue_in;

   logic [9:0]         hv;
   logic signed [10:0] hs;
   logic signed [10:0] d0, d1, d2;
   logic [8:0]         k;
   logic signed [9:0]  op_a, op_b;
   logic signed [19:0] v;
   logic [12:0]        v_shr;
   logic [7:0]         chan_val;

   always_comb begin
      hv = (hue > HUE_MAX) ? '0 : hue;
      hs = $signed({1'b0, hv});
      if (hv < SEG_ONE) begin
         d0 = OFS_170 - hs;
         d1 = hs - OFS_85;
         d2 = -OFS_85;
      end else if (hv < SEG_TWO) begin
         d0 = -OFS_85;
         d1 = OFS_425 - hs;
         d2 = hs - OFS_340;
      end else begin
         d0 = hs - OFS_595;
         d1 = -OFS_85;
         d2 = OFS_680 - hs;
      end
      k = {1'b0, gamma_lookup(bright)} + 9'd1;

      op_a = $signed({2'b00, saturation});
      op_b = d0[9:0];
      case (step_ff)
         3'd0: op_b = d0[9:0];
         3'd1: op_b = d1[9:0];
         3'd2: op_b = d2[9:0];
         3'd3: begin
            op_a = $signed({1'b0, k});
            op_b = $signed({2'b00, chan0_ff});
         end
         3'd4: begin
            op_a = $signed({1'b0, k});
            op_b = $signed({2'b00, chan1_ff});
         end
         3'd5: begin
            op_a = $signed({1'b0, k});
            op_b = $signed({2'b00, chan2_ff});
         end
         default: begin
         end
      endcase

      v        = HUE_BASE + prod_ff;
      v_shr    = v[19] ? '0 : v[19:7];
      chan_val = (v_shr > {5'd0, DUTY_MAX}) ? DUTY_MAX : v_shr[7:0];
   end

   always_comb begin
      busy_in  = busy_ff;
      done_in  = done_ff;
      step_in  = step_ff;
      prod_in  = prod_ff;
      chan0_in = chan0_ff;
      chan1_in = chan1_ff;
      chan2_in = chan2_ff;
      red_in   = red_ff;
      green_in = green_ff;
      blue_in  = blue_ff;

      if (ctl.ack) begin
         done_in = 1'b0;
      end

      if (busy_ff) begin
         prod_in = 20'(op_a) * 20'(op_b);
         case (step_ff)
            3'd1: chan0_in = chan_val;
            3'd2: chan1_in = chan_val;
            3'd3: chan2_in = chan_val;
            3'd4: red_in   = prod_ff[15:8];
            3'd5: green_in = prod_ff[15:8];
            3'd6: blue_in  = prod_ff[15:8];
            default: begin
            end
         endcase
         if (step_ff == STEP_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            step_in = step_ff + 3'd1;
         end
      end else if (ctl.start) begin
         busy_in = 1'b1;
         step_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff  <= prod_in;
      chan0_ff <= chan0_in;
      chan1_ff <= chan1_in;
      chan2_ff <= chan2_in;
      red_ff   <= red_in;
      green_ff <= green_in;
      blue_ff  <= blue_in;
   end

   assign red   = red_ff;
   assign green = green_ff;
   assign blue  = blue_ff;
   assign done  = done_ff;

endmodule

@@ rtl/core/hsb_led_effect_engine.sv @@
// LED effect engine: hue/saturation/brightness to red, green and blue duty values.
// Request channel (req_valid, req_stall, req_advance): one transfer per tick item;
// req_advance high lets one millisecond elapse for the active effect mode.
// Response channel (rsp_valid, rsp_stall, rsp_*): one transfer per request, carrying
// the three duty values and the working hue and brightness after the tick.
// Configuration channel (csr_valid, csr_ready, csr_index, csr_data): csr_ready is
// always high; a transfer writes the register at csr_index, indexes above 6 drop.
// Write configuration only while no request is in flight.
// The color path runs six multiplies through one shared multiplier under a step
// counter, so one request occupies the block until its response enters the
// response register; req_stall is high meanwhile.
// The response register parts the two sides: while rsp_stall holds the response,
// the next request is computed and then waits inside until the register frees.
// Reset (synchronous, active high) clears both channels, loads the register
// defaults, sets hue 0, brightness index 63 and clears the effect counters.
module hsb_led_effect_engine
   import hsb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_advance,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_red_duty,
   output logic [7:0]  rsp_green_duty,
   output logic [7:0]  rsp_blue_duty,
   output logic [9:0]  rsp_current_hue,
   output logic [5:0]  rsp_current_brightness,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [11:0] csr_data
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_BUSY = 1'b1;

   cfg_type     cfg;
   load_type    load;
   mix_ctl_type mix_ctl;

   logic       state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] red_ff, green_ff, blue_ff;
   logic [9:0] hue_ff;
   logic [5:0] bright_ff;

   logic       accept;
   logic       move;
   logic       mix_done;
   logic [9:0] hue;
   logic [5:0] bright;
   logic [7:0] mix_red, mix_green, mix_blue;
   logic       lit;

   hsb_regs u_regs (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg),
      .load      (load)
   );

   hsb_fx u_fx (
      .clock   (clock),
      .reset   (reset),
      .step    (accept),
      .advance (req_advance),
      .cfg     (cfg),
      .load    (load),
      .hue     (hue),
      .bright  (bright)
   );

   hsb_mix u_mix (
      .clock      (clock),
      .reset      (reset),
      .ctl        (mix_ctl),
      .hue        (hue),
      .bright     (bright),
      .saturation (cfg.saturation),
      .red        (mix_red),
      .green      (mix_green),
      .blue       (mix_blue),
      .done       (mix_done)
   );

   always_comb begin
      req_stall     = (state_ff != ST_IDLE);
      accept        = req_valid & ~req_stall;
      move          = mix_done & (~rsp_valid_ff | ~rsp_stall);
      mix_ctl.start = accept;
      mix_ctl.ack   = move;
      lit           = (cfg.mode != MODE_OFF);

      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (accept) begin
         state_in = ST_BUSY;
      end
      if (move) begin
         state_in     = ST_IDLE;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (move) begin
         red_ff    <= lit ? mix_red : '0;
         green_ff  <= lit ? mix_green : '0;
         blue_ff   <= lit ? mix_blue : '0;
         hue_ff    <= hue;
         bright_ff <= bright;
      end
   end

   assign csr_ready              = 1'b1;
   assign rsp_valid              = rsp_valid_ff;
   assign rsp_red_duty           = red_ff;
   assign rsp_green_duty         = green_ff;
   assign rsp_blue_duty          = blue_ff;
   assign rsp_current_hue        = hue_ff;
   assign rsp_current_brightness = bright_ff;

endmodule
